### sv/mrfd_pkg.sv
// Package: types and constants shared by the Modbus RTU frame delimiter.
`timescale 1ns / 1ps
package mrfd_pkg;

  localparam int DATA_W    = 8;
  localparam int CNT_W     = 9;
  localparam int TICK_W    = 16;
  localparam int CFG_W     = 16;

  // action field codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_BUSY        = 2'd0,
    ST_DONE        = 2'd1,
    ST_TIMEOUT     = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_SLAVE_MODE   = 1'b0,
    REG_BYTE_TIMEOUT = 1'b1
  } cfg_reg_t;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;

  // function codes
  localparam logic [DATA_W-1:0] FC_READ_COILS      = 8'd1;
  localparam logic [DATA_W-1:0] FC_READ_DISCRETE   = 8'd2;
  localparam logic [DATA_W-1:0] FC_READ_HOLDING    = 8'd3;
  localparam logic [DATA_W-1:0] FC_READ_INPUT      = 8'd4;
  localparam logic [DATA_W-1:0] FC_WRITE_COIL      = 8'd5;
  localparam logic [DATA_W-1:0] FC_WRITE_REG       = 8'd6;
  localparam logic [DATA_W-1:0] FC_WRITE_COILS     = 8'd15;
  localparam logic [DATA_W-1:0] FC_WRITE_REGS      = 8'd16;
  localparam logic [DATA_W-1:0] FC_READ_WRITE_REGS = 8'd23;
  localparam int                EXCEPTION_BIT      = 7;

  // frame positions and lengths
  localparam logic [CNT_W-1:0] IDX_FUNC      = 9'd1;
  localparam logic [CNT_W-1:0] IDX_RD_COUNT  = 9'd2;
  localparam logic [CNT_W-1:0] IDX_WR_COUNT  = 9'd6;
  localparam logic [CNT_W-1:0] LEN_EXCEPTION = 9'd5;
  localparam logic [CNT_W-1:0] LEN_FIXED     = 9'd8;
  localparam logic [CNT_W-1:0] LEN_RD_HDR    = 9'd5;
  localparam logic [CNT_W-1:0] LEN_WR_HDR    = 9'd9;
  localparam logic [CNT_W-1:0] LEN_MAX       = 9'd264;

  typedef struct packed {
    logic              action;
    logic [DATA_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] byte_out;
    logic              byte_valid;
    logic [CNT_W-1:0]  byte_index;
    status_t           frame_status;
    logic [CNT_W-1:0]  frame_total;
  } result_t;

endpackage

### sv/mrfd_if.sv
// Interfaces: input item channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps
interface mrfd_in_if;
  import mrfd_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface mrfd_out_if;
  import mrfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] byte_out;
  logic              byte_valid;
  logic [CNT_W-1:0]  byte_index;
  status_t           frame_status;
  logic [CNT_W-1:0]  frame_total;

  modport source (output valid, output byte_out, output byte_valid, output byte_index,
                  output frame_status, output frame_total, input ready);
  modport sink   (input valid, input byte_out, input byte_valid, input byte_index,
                  input frame_status, input frame_total, output ready);
endinterface

### sv/modbus_rtu_frame_delimiter_top.sv
// An accepted transaction passes input register -> frame decision -> result register.
// Throughput: one transaction per cycle while the result sink is not stalling.
// A stalled result register holds one result and the input register takes one more item.
// Reset (synchronous, rst_n low): clears frame state and valid flags,
// sets slave_mode to 0 and byte_timeout_ticks to 1000.
`timescale 1ns / 1ps
module modbus_rtu_frame_delimiter_top (
  input  logic                       clk,
  input  logic                       rst_n,
  mrfd_in_if.sink                    in_ch,
  mrfd_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  mrfd_pkg::cfg_reg_t         cfg_idx,
  input  logic [mrfd_pkg::CFG_W-1:0] cfg_wdata
);
  import mrfd_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_vld;
  logic    advance;
  logic    step;
  result_t res;
  result_t out_res;

  assign in_item.action    = in_ch.action;
  assign in_item.data_byte = in_ch.data_byte;
  assign step              = advance && item_vld;

  mrfd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  mrfd_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .res       (res)
  );

  mrfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (item_vld),
    .res       (res),
    .out_ready (out_ch.ready),
    .advance   (advance),
    .out_valid (out_ch.valid),
    .out_res   (out_res)
  );

  assign out_ch.byte_out     = out_res.byte_out;
  assign out_ch.byte_valid   = out_res.byte_valid;
  assign out_ch.byte_index   = out_res.byte_index;
  assign out_ch.frame_status = out_res.frame_status;
  assign out_ch.frame_total  = out_res.frame_total;

  // a completed frame always ends on a received byte with a nonzero length
  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_status == ST_DONE
      |-> out_ch.byte_valid && out_ch.frame_total != '0)
    else $error("complete frame without byte or length");

  // length is reported only with a completed frame
  a_len_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_status != ST_DONE |-> out_ch.frame_total == '0)
    else $error("frame length outside a complete frame");

  // tick transactions carry no byte and never complete or reject a frame
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.byte_valid
      |-> out_ch.byte_out == '0 && out_ch.byte_index == '0 &&
          (out_ch.frame_status == ST_BUSY || out_ch.frame_status == ST_TIMEOUT))
    else $error("bad tick result");

  // an accepted transaction reaches the result register when the stage advances
  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_ch.valid)
    else $error("result lost after processing");

endmodule

### sv/mrfd_in_reg.sv
// Input register: one transaction per cycle when ready, held until the next stage advances.
`timescale 1ns / 1ps
module mrfd_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mrfd_pkg::item_t in_item,
  input  logic            advance,
  output logic            item_vld,
  output mrfd_pkg::item_t item
);
  import mrfd_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  logic  load;

  assign in_ready = !vld_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

### sv/mrfd_tracker.sv
// Frame tracker: configuration registers, frame state and the per-transaction length decision.
`timescale 1ns / 1ps
module mrfd_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  mrfd_pkg::cfg_reg_t           cfg_idx,
  input  logic [mrfd_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         step,
  input  mrfd_pkg::item_t              item,
  output mrfd_pkg::result_t            res
);
  import mrfd_pkg::*;

  logic              slave_r;
  logic [TICK_W-1:0] timeout_r;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  exp_r, exp_nxt;
  logic              known_r, known_nxt;
  logic [TICK_W-1:0] wait_r, wait_nxt;

  logic [CNT_W-1:0]  cnt_inc;
  logic [TICK_W-1:0] wait_inc;
  logic [CNT_W-1:0]  data_ext;

  assign cnt_inc  = cnt_r + 1'b1;
  assign wait_inc = (wait_r != {TICK_W{1'b1}}) ? wait_r + 1'b1 : wait_r;
  assign data_ext = {{(CNT_W-DATA_W){1'b0}}, item.data_byte};

  always_comb begin
    logic unsup;
    logic restart;

    cnt_nxt   = cnt_r;
    exp_nxt   = exp_r;
    known_nxt = known_r;
    wait_nxt  = wait_r;
    res       = '0;
    res.frame_status = ST_BUSY;
    unsup     = 1'b0;
    restart   = 1'b0;

    if (item.action == ACT_TICK) begin
      if (cnt_r != '0) begin
        wait_nxt = wait_inc;
        if (wait_inc >= timeout_r) begin
          res.frame_status = ST_TIMEOUT;
          restart = 1'b1;
        end
      end
    end else begin
      res.byte_out   = item.data_byte;
      res.byte_valid = 1'b1;
      res.byte_index = cnt_r;
      wait_nxt       = '0;
      cnt_nxt        = cnt_inc;

      if (cnt_r == IDX_FUNC) begin
        if (!slave_r) begin
          // master: parse responses
          priority if (item.data_byte[EXCEPTION_BIT]) begin
            exp_nxt   = LEN_EXCEPTION;
            known_nxt = 1'b1;
          end else if (item.data_byte == FC_READ_COILS || item.data_byte == FC_READ_DISCRETE ||
                       item.data_byte == FC_READ_HOLDING || item.data_byte == FC_READ_INPUT ||
                       item.data_byte == FC_READ_WRITE_REGS) begin
            // length comes with the byte count
          end else if (item.data_byte == FC_WRITE_COIL || item.data_byte == FC_WRITE_REG ||
                       item.data_byte == FC_WRITE_COILS || item.data_byte == FC_WRITE_REGS) begin
            exp_nxt   = LEN_FIXED;
            known_nxt = 1'b1;
          end else begin
            unsup = 1'b1;
          end
        end else begin
          // slave: parse requests
          priority if (item.data_byte == FC_READ_COILS || item.data_byte == FC_READ_DISCRETE ||
                       item.data_byte == FC_READ_HOLDING || item.data_byte == FC_READ_INPUT ||
                       item.data_byte == FC_WRITE_COIL || item.data_byte == FC_WRITE_REG) begin
            exp_nxt   = LEN_FIXED;
            known_nxt = 1'b1;
          end else if (item.data_byte == FC_WRITE_COILS ||
                       item.data_byte == FC_WRITE_REGS) begin
            // length comes with the byte count
          end else begin
            unsup = 1'b1;
          end
        end
      end else if (!known_r) begin
        if (cnt_r == IDX_RD_COUNT && !slave_r) begin
          exp_nxt   = LEN_RD_HDR + data_ext;
          known_nxt = 1'b1;
        end else if (cnt_r == IDX_WR_COUNT && slave_r) begin
          exp_nxt   = LEN_WR_HDR + data_ext;
          known_nxt = 1'b1;
        end
      end

      priority if (unsup) begin
        res.frame_status = ST_UNSUPPORTED;
        restart = 1'b1;
      end else if (known_nxt && cnt_inc >= exp_nxt) begin
        res.frame_status = ST_DONE;
        res.frame_total  = cnt_inc;
        restart = 1'b1;
      end else if (cnt_inc > LEN_MAX) begin
        // length never decided: drop the runaway frame
        restart = 1'b1;
      end else begin
        // frame still in progress: hold its state
      end
    end

    if (restart) begin
      cnt_nxt   = '0;
      exp_nxt   = '0;
      known_nxt = 1'b0;
      wait_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r   <= 1'b0;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SLAVE_MODE:   slave_r   <= cfg_wdata[0];
        REG_BYTE_TIMEOUT: timeout_r <= cfg_wdata[TICK_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      exp_r   <= '0;
      known_r <= 1'b0;
      wait_r  <= '0;
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      exp_r   <= exp_nxt;
      known_r <= known_nxt;
      wait_r  <= wait_nxt;
    end
  end

endmodule

### sv/mrfd_out_reg.sv
// Result register: holds one result transaction until the sink takes it.
`timescale 1ns / 1ps
module mrfd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_vld,
  input  mrfd_pkg::result_t res,
  input  logic              out_ready,
  output logic              advance,
  output logic              out_valid,
  output mrfd_pkg::result_t out_res
);
  import mrfd_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign advance = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

### test/tb.sv
// Testbench for the Modbus RTU frame delimiter: random frames, ticks and noise checked by a scoreboard.
`timescale 1ns / 1ps
module tb;
  import mrfd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 140;
  localparam int NUM_PHASES    = 9;
  localparam bit PHASE_MODE[NUM_PHASES]    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam int PHASE_TIMEOUT[NUM_PHASES] = '{6, 1, 65535, 12, 1, 65535, 3, 5, 20};
  localparam logic [DATA_W-1:0] KNOWN_FC[9] = '{FC_READ_COILS, FC_READ_DISCRETE,
    FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS,
    FC_WRITE_REGS, FC_READ_WRITE_REGS};

  // Tracks the frame state of the block and holds the results it owes.
  class frame_checker;
    bit                slave_mode;
    logic [TICK_W-1:0] timeout_ticks;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  frame_len;
    bit                len_known;
    logic [DATA_W-1:0] func_code;
    logic [TICK_W-1:0] idle_ticks;
    result_t           due_results[$];
    int                errors;

    function new();
      slave_mode    = 1'b0;
      timeout_ticks = TIMEOUT_RST;
      errors        = 0;
      restart();
    endfunction

    function void restart();
      rx_count   = '0;
      frame_len  = '0;
      len_known  = 1'b0;
      func_code  = '0;
      idle_ticks = '0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
      if (r == REG_SLAVE_MODE) slave_mode = v[0];
      else timeout_ticks = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_item(item_t it);
      result_t          r;
      logic [CNT_W-1:0] idx;
      bit               unsupported;
      r = '0;
      r.frame_status = ST_BUSY;
      unsupported = 1'b0;
      if (it.action == ACT_TICK) begin
        if (rx_count != 0) begin
          if (idle_ticks != '1) idle_ticks++;
          if (idle_ticks >= timeout_ticks) begin
            r.frame_status = ST_TIMEOUT;
            restart();
          end
        end
      end else begin
        idx          = rx_count;
        r.byte_out   = it.data_byte;
        r.byte_valid = 1'b1;
        r.byte_index = idx;
        idle_ticks   = '0;
        rx_count     = idx + 1'b1;
        if (idx == IDX_FUNC) begin
          func_code = it.data_byte;
          if (!slave_mode) begin
            if (it.data_byte[EXCEPTION_BIT]) begin
              frame_len = LEN_EXCEPTION;
              len_known = 1'b1;
            end else begin
              case (it.data_byte)
                FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
                FC_READ_WRITE_REGS: ; // length comes with the byte count
                FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: begin
                  frame_len = LEN_FIXED;
                  len_known = 1'b1;
                end
                default: unsupported = 1'b1;
              endcase
            end
          end else begin
            case (it.data_byte)
              FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
              FC_WRITE_COIL, FC_WRITE_REG: begin
                frame_len = LEN_FIXED;
                len_known = 1'b1;
              end
              FC_WRITE_COILS, FC_WRITE_REGS: ; // length comes with the byte count
              default: unsupported = 1'b1;
            endcase
          end
        end else if (!len_known) begin
          if (idx == IDX_RD_COUNT && !slave_mode) begin
            frame_len = LEN_RD_HDR + CNT_W'(it.data_byte);
            len_known = 1'b1;
          end else if (idx == IDX_WR_COUNT && slave_mode) begin
            frame_len = LEN_WR_HDR + CNT_W'(it.data_byte);
            len_known = 1'b1;
          end
        end
        if (unsupported) begin
          r.frame_status = ST_UNSUPPORTED;
          restart();
        end else if (len_known && rx_count >= frame_len) begin
          r.frame_status = ST_DONE;
          r.frame_total  = rx_count;
          restart();
        end else if (rx_count > LEN_MAX) begin
          restart();
        end
      end
      due_results.push_back(r);
    endfunction

    function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      want = due_results.pop_front();
      cmp_field("byte_out", 16'(want.byte_out), 16'(got.byte_out));
      cmp_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
      cmp_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
      cmp_field("frame_status", 16'(want.frame_status), 16'(got.frame_status));
      cmp_field("frame_total", 16'(want.frame_total), 16'(got.frame_total));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_reg_t             cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   src_idle_pct;
  int                   snk_idle_pct;
  int                   items_sent;
  int                   cycle_cnt;
  frame_checker         sb;

  mrfd_in_if  in_ch();
  mrfd_out_if out_ch();

  modbus_rtu_frame_delimiter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: check each transaction, then pick the next ready at random.
  initial begin
    result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.byte_out     = out_ch.byte_out;
        got.byte_valid   = out_ch.byte_valid;
        got.byte_index   = out_ch.byte_index;
        got.frame_status = out_ch.frame_status;
        got.frame_total  = out_ch.frame_total;
        sb.check_result(got);
      end
      out_ch.ready <= (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Leave valid untouched on return so a following item can keep it high.
  task automatic send_item(input logic act, input logic [DATA_W-1:0] d);
    item_t it;
    it.action    = act;
    it.data_byte = d;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.action    <= 1'($urandom);
      in_ch.data_byte <= DATA_W'($urandom);
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= d;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    items_sent++;
  endtask

  // Drain the pipeline before touching a register.
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(r, v);
  endtask

  // Build a frame laid out as a request or a response, sometimes cut short.
  task automatic send_frame(input bit as_request);
    logic [DATA_W-1:0] fc;
    logic [DATA_W-1:0] bytes_q[$];
    int                n_data;
    int                pick;
    bit                has_count;
    bit                cut;
    pick   = $urandom_range(99);
    n_data = ($urandom_range(39) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 12);
    if (pick < 12) fc = 8'h80 | DATA_W'($urandom);
    else if (pick < 20) fc = DATA_W'($urandom);
    else fc = KNOWN_FC[$urandom_range(8)];
    bytes_q.push_back(DATA_W'($urandom));
    bytes_q.push_back(fc);
    if (as_request) has_count = fc inside {FC_WRITE_COILS, FC_WRITE_REGS};
    else has_count = !fc[EXCEPTION_BIT] && (fc inside {FC_READ_COILS, FC_READ_DISCRETE,
                       FC_READ_HOLDING, FC_READ_INPUT, FC_READ_WRITE_REGS});
    if (!as_request && fc[EXCEPTION_BIT]) begin
      bytes_q.push_back(DATA_W'($urandom));
    end else if (has_count) begin
      if (as_request) repeat (4) bytes_q.push_back(DATA_W'($urandom));
      bytes_q.push_back(DATA_W'(n_data));
      repeat (n_data) bytes_q.push_back(DATA_W'($urandom));
    end else begin
      repeat (4) bytes_q.push_back(DATA_W'($urandom));
    end
    repeat (2) bytes_q.push_back(DATA_W'($urandom));
    cut = ($urandom_range(9) == 0);
    if (cut) bytes_q = bytes_q[0:$urandom_range(bytes_q.size() - 2)];
    foreach (bytes_q[i]) begin
      if ($urandom_range(11) == 0)
        repeat ($urandom_range(1, 3)) send_item(ACT_TICK, DATA_W'($urandom));
      send_item(ACT_BYTE, bytes_q[i]);
    end
    // let a short timeout expire on the truncated frame
    if (cut) repeat ($urandom_range(1, 40)) send_item(ACT_TICK, DATA_W'($urandom));
  endtask

  initial begin
    logic [DATA_W-1:0] dir_bytes[$];
    int                target;
    sb           = new();
    src_idle_pct = 37;
    snk_idle_pct = 53;
    items_sent   = 0;
    cycle_cnt    = 0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= REG_SLAVE_MODE;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_BYTE;
    in_ch.data_byte <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle tick, exception, unsupported code, empty read, write echo, timeout
    write_reg(REG_BYTE_TIMEOUT, 16'd2);
    send_item(ACT_TICK, 8'hFF);
    dir_bytes = '{8'hFF, 8'h80, 8'h02, 8'hAA, 8'h55,
                  8'h00, 8'h00,
                  8'h01, FC_READ_HOLDING, 8'h00, 8'h12, 8'h34,
                  8'h01, FC_WRITE_REG, 8'h00, 8'h01, 8'h00, 8'h03, 8'h98, 8'h0B,
                  8'h01};
    foreach (dir_bytes[i]) send_item(ACT_BYTE, dir_bytes[i]);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin src_idle_pct = 37; snk_idle_pct = 53; end
        1: begin src_idle_pct = 53; snk_idle_pct = 37; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      write_reg(REG_SLAVE_MODE, {15'($urandom), PHASE_MODE[p]});
      write_reg(REG_BYTE_TIMEOUT, CFG_W'(PHASE_TIMEOUT[p]));
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(1, 6)) send_item(1'($urandom), DATA_W'($urandom));
        else
          send_frame(PHASE_MODE[p] ^ ($urandom_range(9) == 0));
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
